[rtl/mts_pkg.sv]
`default_nettype none

package mts_pkg;

	localparam int DEPTH  = 256;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = IDX_W + 1;
	localparam int DATA_W = 32;
	localparam int OCC_W  = 9;

	typedef logic [CNT_W-1:0]         count_t;
	typedef logic [IDX_W-1:0]         index_t;
	typedef logic signed [DATA_W-1:0] data_t;

	typedef enum logic {
		MODE_PUSH = 1'b0,
		MODE_POP  = 1'b1
	} mode_t;

	typedef enum logic [1:0] {
		STAT_OK        = 2'd0,
		STAT_UNDERFLOW = 2'd1,
		STAT_OVERFLOW  = 2'd2
	} status_t;

endpackage

`default_nettype wire

[rtl/mts_req_if.sv]
`default_nettype none

interface mts_req_if;
	import mts_pkg::*;

	logic  valid;
	logic  ready;
	logic  mode;
	data_t push_value;

	modport source (output valid, output mode, output push_value, input ready);
	modport sink   (input valid, input mode, input push_value, output ready);
endinterface

`default_nettype wire

[rtl/mts_rsp_if.sv]
`default_nettype none

interface mts_rsp_if;
	import mts_pkg::*;

	logic             valid;
	logic             ready;
	data_t            popped_value;
	data_t            current_min;
	logic             min_valid;
	status_t          status;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, output popped_value, output current_min,
		output min_valid, output status, output occupancy, input ready);
	modport sink   (input valid, input popped_value, input current_min,
		input min_valid, input status, input occupancy, output ready);
endinterface

`default_nettype wire

[rtl/min_tracking_stack.sv]
`default_nettype none

// Channel  Dir  Payload                                                   Accepted when
// req      in   mode, push_value                                          valid && ready
// rsp      out  popped_value, current_min, min_valid, status, occupancy   valid && ready
//
// A push completes in S_IDLE and a pop also passes through S_REFILL: the entries below
// the top live in synchronous RAMs, so a pop waits in S_REFILL for the read of the new
// top value and new top minimum. The top value and top minimum are held in registers.
// Results sit in an output register; a request is taken in S_IDLE once it is free or draining.
// Reset clears the counts and the output register; RAM contents need no clearing.

module min_tracking_stack (
	input wire logic clk,
	input wire logic arst_n,
	mts_req_if.sink  req,
	mts_rsp_if.source rsp
);
	import mts_pkg::*;

	typedef enum logic {
		S_IDLE,
		S_REFILL
	} state_t;

	state_t state_q;
	count_t vcount_q;
	count_t mcount_q;
	data_t  top_val_q;
	data_t  top_min_q;
	data_t  popped_s1;
	logic   drop_s1;

	logic             out_valid_q;
	data_t            out_popped_q;
	data_t            out_min_q;
	logic             out_min_valid_q;
	status_t          out_status_q;
	logic [OCC_W-1:0] out_occ_q;

	logic  accept;
	logic  out_free;
	logic  out_load;
	logic  is_pop;
	logic  full;
	logic  empty;
	logic  take_min;
	logic  drop_min;
	logic  push_ok;
	logic  pop_ok;
	data_t vram_rdata;
	data_t mram_rdata;
	index_t vram_raddr;
	index_t mram_raddr;

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign is_pop    = (req.mode == MODE_POP);
	assign full      = (vcount_q == CNT_W'(DEPTH));
	assign empty     = (vcount_q == '0);
	assign take_min  = (mcount_q == '0) || (req.push_value <= top_min_q);
	assign drop_min  = (top_val_q == top_min_q);
	assign push_ok   = accept && !is_pop && !full;
	assign pop_ok    = accept && is_pop && !empty;
	// A result is produced by every push, by a failed pop, and by the S_REFILL state of a pop.
	assign out_load  = (state_q == S_REFILL) || (accept && (!is_pop || empty));

	// After a pop the new top sits one below the new count.
	assign vram_raddr = IDX_W'(vcount_q - CNT_W'(2));
	assign mram_raddr = IDX_W'(mcount_q - CNT_W'(2));

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_value_ram (
		.clk   (clk),
		.we    (push_ok),
		.waddr (vcount_q[IDX_W-1:0]),
		.wdata (req.push_value),
		.re    (pop_ok),
		.raddr (vram_raddr),
		.rdata (vram_rdata)
	);

	mts_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_min_ram (
		.clk   (clk),
		.we    (push_ok && take_min),
		.waddr (mcount_q[IDX_W-1:0]),
		.wdata (req.push_value),
		.re    (pop_ok && drop_min),
		.raddr (mram_raddr),
		.rdata (mram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			vcount_q        <= '0;
			mcount_q        <= '0;
			top_val_q       <= '0;
			top_min_q       <= '0;
			popped_s1       <= '0;
			drop_s1         <= 1'b0;
			out_valid_q     <= 1'b0;
			out_popped_q    <= '0;
			out_min_q       <= '0;
			out_min_valid_q <= 1'b0;
			out_status_q    <= STAT_OK;
			out_occ_q       <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						out_popped_q <= '0;
						if (!is_pop) begin
							if (full) begin
								out_min_q       <= top_min_q;
								out_min_valid_q <= 1'b1;
								out_status_q    <= STAT_OVERFLOW;
								out_occ_q       <= OCC_W'(vcount_q);
							end else begin
								vcount_q        <= vcount_q + CNT_W'(1);
								top_val_q       <= req.push_value;
								out_min_valid_q <= 1'b1;
								out_status_q    <= STAT_OK;
								out_occ_q       <= OCC_W'(vcount_q + CNT_W'(1));
								if (take_min) begin
									mcount_q  <= mcount_q + CNT_W'(1);
									top_min_q <= req.push_value;
									out_min_q <= req.push_value;
								end else begin
									out_min_q <= top_min_q;
								end
							end
						end else begin
							if (empty) begin
								out_min_q       <= '0;
								out_min_valid_q <= 1'b0;
								out_status_q    <= STAT_UNDERFLOW;
								out_occ_q       <= '0;
							end else begin
								vcount_q  <= vcount_q - CNT_W'(1);
								popped_s1 <= top_val_q;
								drop_s1   <= drop_min;
								if (drop_min) begin
									mcount_q <= mcount_q - CNT_W'(1);
								end
								state_q <= S_REFILL;
							end
						end
					end
				end
				S_REFILL: begin
					// The RAM reads issued by the pop have landed.
					top_val_q       <= vram_rdata;
					out_popped_q    <= popped_s1;
					out_min_valid_q <= (mcount_q != '0);
					out_status_q    <= STAT_OK;
					out_occ_q       <= OCC_W'(vcount_q);
					if (mcount_q == '0) begin
						out_min_q <= '0;
					end else if (drop_s1) begin
						out_min_q <= mram_rdata;
					end else begin
						out_min_q <= top_min_q;
					end
					if (drop_s1) begin
						top_min_q <= mram_rdata;
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.valid        = out_valid_q;
	assign rsp.popped_value = out_popped_q;
	assign rsp.current_min  = out_min_q;
	assign rsp.min_valid    = out_min_valid_q;
	assign rsp.status       = out_status_q;
	assign rsp.occupancy    = out_occ_q;

`ifndef ASSERT_OFF
	a_min_le_count: assert property (@(posedge clk) disable iff (!arst_n)
		mcount_q <= vcount_q)
		else $error("minimum count exceeds value count");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNT_W'(DEPTH))
		else $error("value count beyond depth");

	a_nonempty_has_min: assert property (@(posedge clk) disable iff (!arst_n)
		(vcount_q != '0) |-> (mcount_q != '0))
		else $error("stack holds values but no minimum");

	a_refill_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_REFILL) |-> !req.ready)
		else $error("request taken while refilling the top");

	a_push_counts: assert property (@(posedge clk) disable iff (!arst_n)
		push_ok |=> (vcount_q == $past(vcount_q) + CNT_W'(1)))
		else $error("push did not advance the count");
`endif

endmodule

`default_nettype wire

[rtl/mts_ram.sv]
`default_nettype none

module mts_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

[test/min_tracking_stack_tb.sv]
`default_nettype none

module min_tracking_stack_tb;
	import mts_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int STALL_LIMIT = 2000;
	localparam int HOLD_OFF_CYCLES = 300;
	localparam int TAIL_CYCLES = 8;

	typedef struct packed {
		data_t            popped_value;
		data_t            current_min;
		logic             min_valid;
		status_t          status;
		logic [OCC_W-1:0] occupancy;
	} stack_result_t;

	logic clk;
	logic arst_n;

	mts_req_if req_ch ();
	mts_rsp_if rsp_ch ();

	min_tracking_stack u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	// Predicted stack contents, advanced on every accepted request.
	data_t stack_vals [DEPTH];
	data_t stack_mins [DEPTH];
	int    vals_held;
	int    mins_held;

	stack_result_t pending_results[$];

	int errors = 0;
	int send_idle_pct;
	int recv_idle_pct;
	int hold_off_requests = 0;
	int hold_off_seen = 0;
	int hold_off_left = 0;
	int stall_cycles = 0;

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	function automatic stack_result_t apply_stack_op(mode_t op, data_t value);
		stack_result_t r;
		r = '0;
		r.status = STAT_OK;
		if (op == MODE_PUSH) begin
			if (vals_held >= DEPTH) begin
				r.status = STAT_OVERFLOW;
			end else begin
				stack_vals[vals_held] = value;
				vals_held++;
				if (mins_held == 0) begin
					stack_mins[0] = value;
					mins_held = 1;
				end else if (mins_held < DEPTH && value <= stack_mins[mins_held-1]) begin
					stack_mins[mins_held] = value;
					mins_held++;
				end
			end
		end else begin
			if (vals_held == 0) begin
				r.status = STAT_UNDERFLOW;
			end else begin
				r.popped_value = stack_vals[vals_held-1];
				if (mins_held > 0 && r.popped_value == stack_mins[mins_held-1])
					mins_held--;
				vals_held--;
			end
		end
		if (mins_held > 0) begin
			r.current_min = stack_mins[mins_held-1];
			r.min_valid = 1'b1;
		end
		r.occupancy = OCC_W'(vals_held);
		return r;
	endfunction

	// Called just after a falling edge; returns just after the falling edge that follows acceptance.
	task automatic send_request(mode_t op, data_t value);
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid = 1'b0;
			@(negedge clk);
		end
		req_ch.valid = 1'b1;
		req_ch.mode = op;
		req_ch.push_value = value;
		do
			@(posedge clk);
		while (!req_ch.ready);
		pending_results.push_back(apply_stack_op(op, value));
		@(negedge clk);
		req_ch.valid = 1'b0;
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	function automatic data_t pick_value();
		data_t base;
		base = (mins_held > 0) ? stack_mins[mins_held-1] : '0;
		case ($urandom_range(9))
			0, 1, 2, 3: return data_t'($signed($urandom_range(8)) - 4);
			4, 5:       return data_t'($urandom);
			6: begin
				case ($urandom_range(3))
					0: return 32'sh7fffffff;
					1: return 32'sh80000000;
					2: return -32'sd1;
					default: return '0;
				endcase
			end
			default: return base + data_t'($signed($urandom_range(2)) - 1);
		endcase
	endfunction

	// Receiver: random ready, or a long hold-off when a test asks for one.
	always @(negedge clk) begin
		if (hold_off_seen != hold_off_requests) begin
			hold_off_seen = hold_off_requests;
			hold_off_left = HOLD_OFF_CYCLES;
		end
		if (!arst_n) begin
			rsp_ch.ready = 1'b0;
		end else if (hold_off_left > 0) begin
			hold_off_left--;
			rsp_ch.ready = 1'b0;
		end else begin
			rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		stack_result_t exp_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_r = pending_results.pop_front();
				if (rsp_ch.popped_value !== exp_r.popped_value) begin
					$error("popped_value: expected %0d, got %0d",
						exp_r.popped_value, rsp_ch.popped_value);
					errors++;
				end
				if (rsp_ch.current_min !== exp_r.current_min) begin
					$error("current_min: expected %0d, got %0d",
						exp_r.current_min, rsp_ch.current_min);
					errors++;
				end
				if (rsp_ch.min_valid !== exp_r.min_valid) begin
					$error("min_valid: expected %0d, got %0d",
						exp_r.min_valid, rsp_ch.min_valid);
					errors++;
				end
				if (rsp_ch.status !== exp_r.status) begin
					$error("status: expected %s, got %s",
						exp_r.status.name(), rsp_ch.status.name());
					errors++;
				end
				if (rsp_ch.occupancy !== exp_r.occupancy) begin
					$error("occupancy: expected %0d, got %0d",
						exp_r.occupancy, rsp_ch.occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
			stall_cycles = 0;
		else
			stall_cycles++;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic test_directed();
		send_request(MODE_POP, 32'sh12345678);
		send_request(MODE_PUSH, 32'sd0);
		send_request(MODE_PUSH, 32'sh7fffffff);
		send_request(MODE_PUSH, -32'sd1);
		send_request(MODE_PUSH, 32'sh80000000);
		// A second copy of the minimum must be tracked so one pop leaves it in place.
		send_request(MODE_PUSH, 32'sh80000000);
		send_request(MODE_PUSH, 32'sd5);
		send_request(MODE_POP, 32'shffffffff);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_PUSH, -32'sd1);
		send_request(MODE_PUSH, 32'sd3);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
		send_request(MODE_POP, '0);
	endtask

	task automatic test_full_stack();
		while (vals_held > 0)
			send_request(MODE_POP, data_t'($urandom));
		repeat (DEPTH + 2)
			send_request(MODE_PUSH, pick_value());
		repeat (DEPTH + 1)
			send_request(MODE_POP, data_t'($urandom));
	endtask

	task automatic test_random_walk(int n_items);
		int push_pct;
		push_pct = 50;
		for (int i = 0; i < n_items; i++) begin
			if (i % 64 == 0) begin
				case ($urandom_range(2))
					0: push_pct = 10;
					1: push_pct = 50;
					default: push_pct = 90;
				endcase
			end
			if ($urandom_range(99) < push_pct)
				send_request(MODE_PUSH, pick_value());
			else
				send_request(MODE_POP, data_t'($urandom));
		end
	endtask

	task automatic test_back_pressure();
		hold_off_requests++;
		// The block fills its output register and stalls requests until the hold ends.
		for (int i = 0; i < 40; i++) begin
			if ($urandom_range(2) != 0)
				send_request(MODE_PUSH, pick_value());
			else
				send_request(MODE_POP, data_t'($urandom));
		end
		wait_drained();
	endtask

	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.mode = MODE_PUSH;
		req_ch.push_value = '0;
		vals_held = 0;
		mins_held = 0;
		send_idle_pct = 26;
		recv_idle_pct = 59;
		repeat (6) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_directed();
		wait_drained();

		send_idle_pct = 59;
		recv_idle_pct = 26;
		test_full_stack();

		send_idle_pct = 26;
		recv_idle_pct = 59;
		test_random_walk(330);
		wait_drained();

		send_idle_pct = 59;
		recv_idle_pct = 26;
		test_random_walk(330);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random_walk(330);

		test_back_pressure();
		test_random_walk(60);

		wait_drained();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

`default_nettype wire
